// ----- hw/rtl/kstack_pkg.sv -----
`default_nettype none

package kstack_pkg;

    localparam int KEY_W      = 88;
    localparam int HIGH_W     = 24;
    localparam int LOW_W      = 64;
    localparam int MAX_RESULTS = 10;

    // command codes
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_POP    = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_LIST   = 3'd3;
    localparam logic [2:0] CMD_SEARCH = 3'd4;

    // status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_OVERFLOW  = 3'd1;
    localparam logic [2:0] STS_UNDERFLOW = 3'd2;
    localparam logic [2:0] STS_NOTFOUND  = 3'd3;
    localparam logic [2:0] STS_FOUND     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DATA
    } kstack_state_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [HIGH_W-1:0] key_high;
        logic [LOW_W-1:0]  key_low;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [HIGH_W-1:0] out_high;
        logic [LOW_W-1:0]  out_low;
        logic              last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic       rd_top;
        logic       idx_clr;
        logic       idx_inc;
        logic       push_wr;
        logic       pop_dec;
        logic       emit;
        logic       emit_data;
        logic       emit_last;
        logic [2:0] emit_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       full;
        logic       rsp_free;
        logic       match;
        logic       list_last;
        logic       scan_last;
    } dp_stat_t;

    // bits of key_high that a key of kchars characters can use
    function automatic logic [HIGH_W-1:0] high_mask(input int kchars);
        logic [HIGH_W-1:0] m;
        m = '0;
        if (kchars >= 11)
        begin
            m = '1;
        end
        else if (kchars == 10)
        begin
            m = 24'h00FFFF;
        end
        else if (kchars == 9)
        begin
            m = 24'h0000FF;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kstack_ctrl.sv -----
`default_nettype none

module kstack_ctrl
    import kstack_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       dcmd
);

    kstack_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUSH:
                    begin
                        if (stat.rsp_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_POP, CMD_PEEK, CMD_LIST, CMD_SEARCH:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_DATA;
                        end
                        else if (stat.rsp_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DATA:
            begin
                case (stat.cmd)
                    CMD_POP, CMD_PEEK:
                    begin
                        if (stat.rsp_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_LIST:
                    begin
                        if (stat.rsp_free && stat.list_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if ((stat.match || stat.scan_last) && stat.rsp_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        dcmd      = '0;
        dcmd.emit_status = STS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                dcmd.load = req_valid;
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUSH:
                    begin
                        dcmd.emit        = stat.rsp_free;
                        dcmd.emit_last   = 1'b1;
                        dcmd.push_wr     = stat.rsp_free && !stat.full;
                        dcmd.emit_status = stat.full ? STS_OVERFLOW : STS_OK;
                    end
                    CMD_POP, CMD_PEEK, CMD_LIST, CMD_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            dcmd.emit        = stat.rsp_free;
                            dcmd.emit_last   = 1'b1;
                            dcmd.emit_status = STS_UNDERFLOW;
                        end
                        else
                        begin
                            // first read: top entry or the oldest one
                            dcmd.rd_en   = 1'b1;
                            dcmd.rd_top  = (stat.cmd == CMD_POP) || (stat.cmd == CMD_PEEK);
                            dcmd.idx_clr = 1'b1;
                        end
                    end
                    default:
                    begin
                        dcmd.emit = 1'b0;
                    end
                endcase
            end
            S_DATA:
            begin
                case (stat.cmd)
                    CMD_POP, CMD_PEEK:
                    begin
                        dcmd.emit      = stat.rsp_free;
                        dcmd.emit_data = 1'b1;
                        dcmd.emit_last = 1'b1;
                        dcmd.pop_dec   = stat.rsp_free && (stat.cmd == CMD_POP);
                    end
                    CMD_LIST:
                    begin
                        dcmd.emit      = stat.rsp_free;
                        dcmd.emit_data = 1'b1;
                        dcmd.emit_last = stat.list_last;
                        dcmd.rd_en     = stat.rsp_free && !stat.list_last;
                        dcmd.idx_inc   = stat.rsp_free && !stat.list_last;
                    end
                    CMD_SEARCH:
                    begin
                        if (stat.match)
                        begin
                            dcmd.emit        = stat.rsp_free;
                            dcmd.emit_data   = 1'b1;
                            dcmd.emit_last   = 1'b1;
                            dcmd.emit_status = STS_FOUND;
                        end
                        else if (stat.scan_last)
                        begin
                            dcmd.emit        = stat.rsp_free;
                            dcmd.emit_last   = 1'b1;
                            dcmd.emit_status = STS_NOTFOUND;
                        end
                        else
                        begin
                            // one stored key compared per cycle
                            dcmd.rd_en   = 1'b1;
                            dcmd.idx_inc = 1'b1;
                        end
                    end
                    default:
                    begin
                        dcmd.emit = 1'b0;
                    end
                endcase
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kstack_dp.sv -----
`default_nettype none

module kstack_dp
    import kstack_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int LIST_LEN  = 10,
    parameter int KEY_CHARS = 11
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    req,
    output rsp_t         rsp,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    input  wire dp_cmd_t dcmd,
    output dp_stat_t     stat
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int LIST_CAP = (LIST_LEN < MAX_RESULTS) ? LIST_LEN : MAX_RESULTS;
    localparam int LW       = CNT_W + 7;

    logic [KEY_W-1:0]  mem [DEPTH];
    logic [KEY_W-1:0]  rdata_reg;
    logic [2:0]        cmd_reg;
    logic [HIGH_W-1:0] key_high_reg;
    logic [LOW_W-1:0]  key_low_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    logic [CNT_W-1:0]  top_c;
    logic [CNT_W-1:0]  idx_p1;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  waddr;
    logic              rsp_free;

    assign top_c    = count_reg - CNT_W'(1);
    assign idx_p1   = CNT_W'(idx_reg) + CNT_W'(1);
    assign waddr    = count_reg[IDX_W-1:0];
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (dcmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (dcmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
        raddr = dcmd.rd_top ? top_c[IDX_W-1:0] : idx_next;
    end

    always_comb
    begin
        if (dcmd.push_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (dcmd.pop_dec)
        begin
            count_next = top_c;
        end
        else
        begin
            count_next = count_reg;
        end
        if (dcmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // key store, single write port and registered read port
    always_ff @(posedge clk)
    begin
        if (dcmd.push_wr)
        begin
            mem[waddr] <= {key_high_reg, key_low_reg};
        end
        if (dcmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            cmd_reg      <= req.cmd;
            key_high_reg <= req.key_high & high_mask(KEY_CHARS);
            key_low_reg  <= req.key_low;
        end
        if (dcmd.emit)
        begin
            rsp_reg.status <= dcmd.emit_status;
            rsp_reg.last   <= dcmd.emit_last;
            if (dcmd.emit_data)
            begin
                rsp_reg.out_high <= rdata_reg[KEY_W-1 -: HIGH_W];
                rsp_reg.out_low  <= rdata_reg[LOW_W-1:0];
            end
            else
            begin
                rsp_reg.out_high <= '0;
                rsp_reg.out_low  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(DEPTH));
        stat.rsp_free  = rsp_free;
        stat.match     = (rdata_reg == {key_high_reg, key_low_reg});
        stat.scan_last = (idx_p1 == count_reg);
        stat.list_last = (idx_p1 == count_reg) || (LW'(idx_p1) == LW'(LIST_CAP));
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.emit |-> rsp_free)
        else $error("response overwritten while stalled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.push_wr |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not advance count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.pop_dec |-> (count_reg != '0))
        else $error("pop on empty stack");

endmodule

`default_nettype wire

// ----- hw/rtl/key_stack_with_search.sv -----
// LIFO key stack with linear search.
// Request channel: req (cmd, key_high, key_low) with req_valid / req_stall.
// A request is taken when req_valid is high and req_stall is low. Commands:
// push, pop, peek top, list oldest, search; codes 5 to 7 are dropped silently.
// Response channel: rsp (status, out_high, out_low, last) with rsp_valid /
// rsp_stall. Push, pop, peek, search and list on an empty stack give one
// response each; list otherwise gives min(LIST_LEN, 10, count) responses
// with last on the final one. After acceptance, push writes its response
// from the exec state; pop, peek and list first read the key store in exec
// and answer from the data state, list reading one further entry per
// response; search scans the stored keys in the data state, since the key
// store gives one read per cycle. One request is in progress at a time;
// req_stall is high until its final response has entered the output
// register, so a new request is taken while that response still waits.
// When rsp_stall is high a valid response holds in the response register
// and the next response waits for it; a search still scanning runs on.
// Reset empties the stack; stored keys are not cleared.
`default_nettype none

module key_stack_with_search
    import kstack_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int LIST_LEN  = 10,
    parameter int KEY_CHARS = 11
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    kstack_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .dcmd      (dcmd)
    );

    kstack_dp #(
        .DEPTH     (DEPTH),
        .LIST_LEN  (LIST_LEN),
        .KEY_CHARS (KEY_CHARS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dcmd      (dcmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
